// File: design/ptlru_pkg.sv
package ptlru_pkg;

    localparam int VIRT_PAGES_DEF     = 64;
    localparam int PHYS_PAGES_MAX_DEF = 16;

    localparam int VA_W    = 32;
    localparam int PN_W    = 6;
    localparam int FRAME_W = 4;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 5;

    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_DIRTY     = 2'd1;
    localparam logic [1:0] OP_TOUCH     = 2'd2;
    localparam logic [1:0] OP_NOP       = 2'd3;

    localparam logic CFG_PHYS_COUNT = 1'b0;
    localparam logic CFG_OFFSET_W   = 1'b1;

    // Command presented to every cell of the chain.
    typedef struct packed {
        logic                 set_dirty;
        logic                 restamp;
        logic                 map;
        logic                 clear_dirty;
        logic                 inval_frame;
        logic [FRAME_W-1:0]   frame;
        logic [STAMP_W-1:0]   stamp;
    } t_cell_cmd;

    // Running oldest-entry search that travels down the chain.
    typedef struct packed {
        logic                 found;
        logic [STAMP_W-1:0]   stamp;
        logic [FRAME_W-1:0]   frame;
        logic                 dirty;
    } t_search;

endpackage

// File: design/page_table_lru_translate_top.sv
// One item is accepted at a time. Mark-dirty, touch, no-op, hits, faults
// with a free frame and errors pass from the execute state straight to the
// output state. A fault that needs an eviction first scans: the oldest
// stamp is found by a search that moves one entry per cycle down the chain
// of entry cells, then the victim's dirty bit is cleared and all cells
// holding the freed frame invalidate in the same cycle. The result waits
// in an output register until taken; the next item is accepted meanwhile,
// and its result is held back only while the previous one is still waiting.
module page_table_lru_translate_top #(
    parameter int VIRT_PAGES     = ptlru_pkg::VIRT_PAGES_DEF,
    parameter int PHYS_PAGES_MAX = ptlru_pkg::PHYS_PAGES_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op [1:0], virtual_address [33:2], page_number [39:34]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [0], hit [1], physical_address [33:2], frame_number [37:34],
    // evicted [38], evicted_frame [42:39], writeback [43], zero [47:44]
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    localparam int FW = ptlru_pkg::FRAME_W;
    localparam int SW = ptlru_pkg::STAMP_W;
    localparam int IW = (VIRT_PAGES > 1) ? $clog2(VIRT_PAGES) : 1;
    localparam int CW = $clog2(VIRT_PAGES + 1);
    localparam int PW = $clog2(PHYS_PAGES_MAX + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EVCT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_phys_cnt, r_off_bits;
    logic [1:0]  r_op;
    logic [31:0] r_va;
    logic [IW-1:0] r_idx;
    logic        r_err;
    logic [SW-1:0] r_stamp_ctr;
    logic [PW-1:0] r_used;
    logic [CW-1:0] r_cnt;
    logic [47:0] r_out;
    logic        r_out_v;

    ptlru_pkg::t_cell_cmd w_cmd;
    ptlru_pkg::t_search   w_chain [VIRT_PAGES+1];
    logic [VIRT_PAGES-1:0] w_valid, w_sel;
    logic [FW-1:0] w_frame [VIRT_PAGES];
    logic [VIRT_PAGES-1:0] w_best;

    logic [31:0] w_va_in, w_vpn;
    logic [5:0]  w_pn_in;
    logic [1:0]  w_op_in;
    logic        w_in_err;
    logic [IW-1:0] w_in_idx;
    logic [PW-1:0] w_limit;
    logic [31:0] w_offmask, w_pa;
    logic [FW-1:0] w_frame_sel;
    logic        w_acc;
    logic        w_load;
    logic [47:0] w_out;

    assign w_op_in = s_axis_tdata[1:0];
    assign w_va_in = s_axis_tdata[33:2];
    assign w_pn_in = s_axis_tdata[39:34];
    assign w_vpn   = w_va_in >> r_off_bits;
    assign w_acc   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (w_op_in == ptlru_pkg::OP_TOUCH) begin
            w_in_err = 32'(w_pn_in) >= 32'(VIRT_PAGES);
            w_in_idx = IW'(w_pn_in);
        end else begin
            w_in_err = w_vpn >= 32'(VIRT_PAGES);
            w_in_idx = IW'(w_vpn);
        end
    end

    always_comb begin
        if (r_phys_cnt == 5'd0) begin
            w_limit = PW'(1);
        end else if (32'(r_phys_cnt) > 32'(PHYS_PAGES_MAX)) begin
            w_limit = PW'(PHYS_PAGES_MAX);
        end else begin
            w_limit = PW'(r_phys_cnt);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
    assign w_load        = (r_state == ST_OUT) && (!r_out_v || m_axis_tready);

    always_comb begin
        w_sel = '0;
        w_sel[r_idx] = 1'b1;
    end

    assign w_frame_sel = w_frame[r_idx];
    assign w_offmask   = 32'((64'd1 << r_off_bits) - 64'd1);

    always_comb begin
        w_cmd = '0;
        w_cmd.stamp = r_stamp_ctr;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                if (!r_err && r_op == ptlru_pkg::OP_DIRTY) begin
                    w_cmd.set_dirty = 1'b1;
                end else if (!r_err && r_op == ptlru_pkg::OP_TOUCH) begin
                    w_cmd.restamp = 1'b1;
                end else if (!r_err && r_op == ptlru_pkg::OP_TRANSLATE) begin
                    if (w_valid[r_idx]) begin
                        w_cmd.restamp = 1'b1;
                    end else if (r_used < w_limit) begin
                        w_cmd.map   = 1'b1;
                        w_cmd.frame = FW'(r_used);
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(VIRT_PAGES)) begin
                    n_state = ST_EVCT;
                end
            end
            ST_EVCT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Eviction: victim found at chain end; clear its dirty bit, drop every
    // mapping of the freed frame, then map the faulting page.
    logic [IW-1:0] r_victim;
    logic          r_ev_phase;
    ptlru_pkg::t_cell_cmd w_cmd_ev;
    logic [VIRT_PAGES-1:0] w_sel_ev;
    ptlru_pkg::t_search r_res;

    always_comb begin
        w_cmd_ev = w_cmd;
        w_sel_ev = w_sel;
        if (r_state == ST_EVCT) begin
            w_cmd_ev = '0;
            w_cmd_ev.stamp = r_stamp_ctr;
            w_cmd_ev.frame = r_res.found ? r_res.frame : '0;
            if (!r_ev_phase) begin
                w_cmd_ev.inval_frame = r_res.found;
                w_cmd_ev.clear_dirty = r_res.found;
                w_sel_ev = '0;
                w_sel_ev[r_victim] = 1'b1;
            end else begin
                w_cmd_ev.map = 1'b1;
            end
        end
    end

    assign w_chain[0] = '0;
    for (genvar g = 0; g < VIRT_PAGES; g++) begin : g_cell
        ptlru_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_sel    (w_sel_ev[g]),
            .i_cmd    (w_cmd_ev),
            .i_search (w_chain[g]),
            .o_search (w_chain[g+1]),
            .o_valid  (w_valid[g]),
            .o_frame  (w_frame[g]),
            .o_is_best(w_best[g])
        );
    end

    // Victim index: the search token passes cell g while the scan counter equals g.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_cnt < CW'(VIRT_PAGES) && w_best[r_cnt[IW-1:0]]) begin
            r_victim <= r_cnt[IW-1:0];
        end
        if (r_state == ST_SCAN && r_cnt == CW'(VIRT_PAGES)) begin
            r_res <= w_chain[VIRT_PAGES];
        end
    end

    logic w_stamp_now;
    assign w_stamp_now = (w_cmd_ev.restamp || w_cmd_ev.map);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phys_cnt  <= 5'd16;
            r_off_bits  <= 5'd12;
            r_stamp_ctr <= '0;
            r_used      <= '0;
            r_out_v     <= 1'b0;
            r_cnt       <= '0;
            r_ev_phase  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ptlru_pkg::CFG_PHYS_COUNT: r_phys_cnt <= i_cfg_data;
                    ptlru_pkg::CFG_OFFSET_W:   r_off_bits <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_stamp_now) begin
                r_stamp_ctr <= r_stamp_ctr + SW'(1);
            end
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (r_state == ST_EXEC && w_cmd.map) begin
                r_used <= r_used + PW'(1);
            end
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + CW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_EVCT) begin
                r_ev_phase <= !r_ev_phase;
            end
            if (r_state == ST_EVCT && !r_ev_phase) begin
                r_state <= ST_EVCT;
            end else begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op  <= w_op_in;
            r_va  <= w_va_in;
            r_idx <= w_in_idx;
            r_err <= w_in_err && (w_op_in != ptlru_pkg::OP_NOP);
        end
    end

    // Result assembled while the table is updated.
    logic r_hit, r_evd, r_wb;
    logic [FW-1:0] r_fr, r_evf;
    assign w_pa = ((32'(r_fr)) << r_off_bits) | (r_va & w_offmask);

    always_comb begin
        w_out = '0;
        w_out[0] = r_err;
        if (!r_err && r_op == ptlru_pkg::OP_TRANSLATE) begin
            w_out[1]     = r_hit;
            w_out[33:2]  = w_pa;
            w_out[37:34] = r_fr;
            w_out[38]    = r_evd;
            w_out[42:39] = r_evf;
            w_out[43]    = r_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_hit <= w_valid[r_idx];
            r_fr  <= w_valid[r_idx] ? w_frame_sel : FW'(r_used);
            r_evd <= 1'b0;
            r_evf <= '0;
            r_wb  <= 1'b0;
        end
        if (r_state == ST_EVCT && !r_ev_phase) begin
            r_fr  <= r_res.found ? r_res.frame : '0;
            r_evd <= r_res.found;
            r_evf <= r_res.found ? r_res.frame : '0;
            r_wb  <= r_res.found && r_res.dirty;
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end
endmodule

// File: design/ptlru_cell.sv
module ptlru_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sel,
    input  ptlru_pkg::t_cell_cmd  i_cmd,
    input  ptlru_pkg::t_search    i_search,
    output ptlru_pkg::t_search    o_search,
    output logic                  o_valid,
    output logic [ptlru_pkg::FRAME_W-1:0] o_frame,
    output logic                  o_is_best
);
    logic                          r_valid;
    logic                          r_dirty;
    logic [ptlru_pkg::FRAME_W-1:0] r_frame;
    logic [ptlru_pkg::STAMP_W-1:0] r_stamp;
    logic                          w_better;

    assign w_better  = r_valid && (!i_search.found || (r_stamp < i_search.stamp));
    assign o_is_best = w_better;
    assign o_valid   = r_valid;
    assign o_frame   = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_search <= '0;
        end else if (w_better) begin
            o_search <= '{found: 1'b1, stamp: r_stamp, frame: r_frame, dirty: r_dirty};
        end else begin
            o_search <= i_search;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_frame <= '0;
            r_stamp <= '0;
        end else begin
            if (i_cmd.inval_frame && r_frame == i_cmd.frame) begin
                r_valid <= 1'b0;
            end
            if (i_sel) begin
                if (i_cmd.set_dirty) begin
                    r_dirty <= 1'b1;
                end
                if (i_cmd.clear_dirty) begin
                    r_dirty <= 1'b0;
                end
                if (i_cmd.restamp) begin
                    r_stamp <= i_cmd.stamp;
                end
                if (i_cmd.map) begin
                    r_valid <= 1'b1;
                    r_frame <= i_cmd.frame;
                    r_stamp <= i_cmd.stamp;
                end
            end
        end
    end
endmodule

// File: design/ptlru_checker.sv
module ptlru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready held");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[47:1] == '0))
        else $error("error result not clean");
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[38]) |-> !m_axis_tdata[1])
        else $error("eviction on hit");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed");
endmodule

bind page_table_lru_translate_top ptlru_checker u_ptlru_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// File: tb/tb_page_table_lru_translate_top.sv
module tb_page_table_lru_translate_top;

    localparam int NPAGES = 64;
    localparam int NFRAMES = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic        writeback;
        logic [3:0]  evicted_frame;
        logic        evicted;
        logic [3:0]  frame_number;
        logic [31:0] physical_address;
        logic        hit;
        logic        status;
    } t_xlate_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [4:0]  i_cfg_data;

    page_table_lru_translate_top DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow page table.
    logic        pt_valid [NPAGES];
    logic        pt_dirty [NPAGES];
    logic [3:0]  pt_frame [NPAGES];
    logic [31:0] pt_stamp [NPAGES];
    logic [31:0] stamp_now;
    logic [4:0]  frames_taken;
    logic [4:0]  frame_count_reg;
    logic [4:0]  offset_width_reg;

    t_xlate_result pending_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int evictions_seen;
    int cycle_count;
    int ready_hold;
    logic stall_enable;

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_xlate_result predict_translation(logic [1:0] op, logic [31:0] va,
                                                          logic [5:0] pn);
        t_xlate_result r;
        logic [4:0]  sh;
        logic [31:0] vpn;
        logic [4:0]  lim;
        logic [3:0]  fr;
        logic        found;
        int          best;
        r = '0;
        sh = offset_width_reg;
        vpn = va >> sh;
        lim = (frame_count_reg < 1) ? 5'd1 :
              (frame_count_reg > NFRAMES) ? 5'(NFRAMES) : frame_count_reg;
        if (op == ptlru_pkg::OP_NOP) return r;
        if (op == ptlru_pkg::OP_TOUCH) begin
            pt_stamp[pn] = stamp_now;
            stamp_now = stamp_now + 32'd1;
            return r;
        end
        if (vpn >= NPAGES) begin
            r.status = 1'b1;
            return r;
        end
        if (op == ptlru_pkg::OP_DIRTY) begin
            pt_dirty[vpn] = 1'b1;
            return r;
        end
        if (pt_valid[vpn]) begin
            r.hit = 1'b1;
            fr = pt_frame[vpn];
        end else if (frames_taken < lim) begin
            fr = frames_taken[3:0];
            frames_taken = frames_taken + 5'd1;
            pt_frame[vpn] = fr;
            pt_valid[vpn] = 1'b1;
        end else begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < NPAGES; i++)
                if (pt_valid[i] && (!found || pt_stamp[i] < pt_stamp[best])) begin
                    best = i;
                    found = 1'b1;
                end
            fr = 4'd0;
            if (found) begin
                fr = pt_frame[best];
                r.evicted = 1'b1;
                r.evicted_frame = fr;
                r.writeback = pt_dirty[best];
                pt_dirty[best] = 1'b0;
                for (int i = 0; i < NPAGES; i++)
                    if (pt_frame[i] == fr) pt_valid[i] = 1'b0;
            end
            pt_frame[vpn] = fr;
            pt_valid[vpn] = 1'b1;
        end
        pt_stamp[vpn] = stamp_now;
        stamp_now = stamp_now + 32'd1;
        r.physical_address = 32'((64'(fr) << sh) | 64'(va & ((32'd1 << sh) - 32'd1)));
        if (sh == 0) r.physical_address = {28'd0, fr};
        r.frame_number = fr;
        return r;
    endfunction

    function automatic int gap_length(int pct);
        if ($urandom_range(99) >= pct) return 0;
        return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    endfunction

    task automatic send_item(logic [1:0] op, logic [31:0] va, logic [5:0] pn);
        int n;
        n = stall_enable ? gap_length(30) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pn, va, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results = {pending_results, predict_translation(op, va, pn)};
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NPAGES + 10) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [4:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == ptlru_pkg::CFG_PHYS_COUNT) frame_count_reg = value;
        else offset_width_reg = value;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!stall_enable) begin
                m_axis_tready <= 1'b1;
            end else if (ready_hold > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold <= ready_hold - 1;
            end else if ($urandom_range(99) < 2) begin
                m_axis_tready <= 1'b0;
                ready_hold <= $urandom_range(40, 10);
            end else begin
                m_axis_tready <= ($urandom_range(99) < 80);
            end
        end
    end

    always @(posedge i_clk) begin
        t_xlate_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_xlate_result'(m_axis_tdata[43:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result 0x%h arrived with no pending translation", got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.evicted) evictions_seen++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    errors++;
                end
                if (got.physical_address !== want.physical_address) begin
                    $error("physical_address: expected 0x%h, got 0x%h",
                           want.physical_address, got.physical_address);
                    errors++;
                end
                if (got.frame_number !== want.frame_number) begin
                    $error("frame_number: expected %0d, got %0d",
                           want.frame_number, got.frame_number);
                    errors++;
                end
                if (got.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    errors++;
                end
                if (got.evicted_frame !== want.evicted_frame) begin
                    $error("evicted_frame: expected %0d, got %0d",
                           want.evicted_frame, got.evicted_frame);
                    errors++;
                end
                if (got.writeback !== want.writeback) begin
                    $error("writeback: expected %0d, got %0d",
                           want.writeback, got.writeback);
                    errors++;
                end
                if (m_axis_tdata[47:44] !== 4'd0) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[47:44]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] address_for(int page);
        logic [31:0] off;
        off = $urandom;
        if (offset_width_reg == 0) return 32'(page);
        return (32'(page) << offset_width_reg) | (off & ((32'd1 << offset_width_reg) - 32'd1));
    endfunction

    task automatic test_directed_cases();
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_0000, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_0FFF, 6'd0);
        send_item(ptlru_pkg::OP_DIRTY, 32'h0000_0123, 6'd0);
        send_item(ptlru_pkg::OP_TOUCH, 32'h0, 6'd63);
        send_item(ptlru_pkg::OP_NOP, 32'hFFFF_FFFF, 6'd63);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 6'd0);
        send_item(ptlru_pkg::OP_DIRTY, 32'hFFFF_FFFF, 6'd0);
        send_item(ptlru_pkg::OP_DIRTY, 32'h0003_F000, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0003_FFFF, 6'd0);
        write_register(ptlru_pkg::CFG_PHYS_COUNT, 5'd0);
        write_register(ptlru_pkg::CFG_OFFSET_W, 5'd4);
        send_item(ptlru_pkg::OP_DIRTY, 32'h0000_0050, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_0021, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_003F, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_0050, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h0000_03FF, 6'd0);
        write_register(ptlru_pkg::CFG_OFFSET_W, 5'd31);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h7FFF_FFFF, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'h8000_0000, 6'd0);
        write_register(ptlru_pkg::CFG_OFFSET_W, 5'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'd63, 6'd0);
        send_item(ptlru_pkg::OP_TRANSLATE, 32'd64, 6'd0);
        write_register(ptlru_pkg::CFG_PHYS_COUNT, 5'd31);
    endtask

    task automatic run_random_phase(logic [4:0] frames, logic [4:0] offw, int count);
        int r;
        int page;
        write_register(ptlru_pkg::CFG_PHYS_COUNT, frames);
        write_register(ptlru_pkg::CFG_OFFSET_W, offw);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            page = ($urandom_range(3) == 0) ? $urandom_range(NPAGES - 1) : $urandom_range(23);
            if (r < 60)
                send_item(ptlru_pkg::OP_TRANSLATE, address_for(page), 6'($urandom));
            else if (r < 75)
                send_item(ptlru_pkg::OP_DIRTY, address_for(page), 6'($urandom));
            else if (r < 88)
                send_item(ptlru_pkg::OP_TOUCH, 32'($urandom), 6'($urandom));
            else if (r < 95)
                send_item(ptlru_pkg::OP_TRANSLATE, 32'($urandom), 6'($urandom));
            else
                send_item(ptlru_pkg::OP_NOP, 32'($urandom), 6'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(5'd16, 5'd12, 350);
        run_random_phase(5'd1, 5'd4, 200);
        run_random_phase(5'd4, 5'd26, 250);
        stall_enable = 1'b0;
        run_random_phase(5'd8, 5'd8, 200);
        stall_enable = 1'b1;
        run_random_phase(5'd20, 5'd16, 250);
        run_random_phase(5'd11, 5'd0, 150);
        run_random_phase(5'd2, 5'd31, 230);
    endtask

    initial begin
        for (int i = 0; i < NPAGES; i++) begin
            pt_valid[i] = 1'b0;
            pt_dirty[i] = 1'b0;
            pt_frame[i] = 4'd0;
            pt_stamp[i] = 32'd0;
        end
        i_clk = 1'b0;
        stamp_now = 32'd0;
        frames_taken = 5'd0;
        frame_count_reg = 5'd16;
        offset_width_reg = 5'd12;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        evictions_seen = 0;
        cycle_count = 0;
        ready_hold = 0;
        stall_enable = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic();
        drain_results();
        $display("Sent %0d items and checked %0d results, %0d of them with evictions.",
                 items_sent, results_seen, evictions_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
